/* sv/f32asmd_pkg.sv */
// shared types and constants of the single-precision arithmetic unit
package f32asmd_pkg;

	// operation codes
	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_ITOF = 3'd4;
	localparam logic [2:0] OP_UTOF = 3'd5;

	localparam int MAG_W = 56;  // working magnitude, 23 fraction bits
	localparam int EXP_W = 11;  // signed working exponent
	localparam int SIG_W = 24;  // significand with hidden bit
	localparam int QUO_W = 25;  // quotient bits developed by the divider

	localparam logic [7:0]  BIAS        = 8'd127;
	localparam logic [7:0]  ALIGN_LIMIT = 8'd31;
	localparam logic [7:0]  EXP_TOP     = 8'd255;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture and unpack the input transfer
		logic exec;       // align, multiply, divider setup or int conversion
		logic combine;    // signed add of the aligned magnitudes
		logic div_step;   // one restoring quotient bit
		logic norm_step;  // one normalization shift
		logic round;      // last-bit rounding and zero result
		logic emit;       // write the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic special;    // result is a fixed pattern, no arithmetic
		logic is_addsub;
		logic is_div;
		logic div_last;
		logic norm_done;
		logic out_free;
	} sts_t;

endpackage

/* sv/f32asmd_dp.sv */
// datapath of the single-precision arithmetic unit
module f32asmd_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  f32asmd_pkg::cmd_t   cmd,
	output f32asmd_pkg::sts_t   sts,
	input  logic [2:0]          op_in,
	input  logic [63:0]         data_in,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic [0:0]          m_tuser
);
	import f32asmd_pkg::*;

	// unpacked operands
	logic [2:0]            op_q;
	logic                  sa_q, sb_q;
	logic [7:0]            ea_q, eb_q;
	logic [SIG_W-1:0]      fa_q, fb_q;
	logic [31:0]           raw_a_q;

	// working value
	logic [MAG_W-1:0]      mag_q, aux_q;
	logic signed [EXP_W-1:0] ex_q;
	logic                  sgn_q;
	logic                  rbit_q;
	logic [SIG_W-1:0]      rem_q;
	logic                  nbit_q;
	logic [4:0]            cnt_q;
	logic [31:0]           spec_q;
	logic                  spec_sel_q;

	// output register
	logic                  ovalid_q;
	logic [31:0]           obits_q;
	logic                  oflag_q;

	logic [31:0]           in_a, in_b;
	logic                  is_div, special;

	// alignment
	logic                  swap;
	logic [7:0]            hi_e, lo_e, exp_gap, rsh;
	logic [SIG_W-1:0]      hi_m, lo_m, lo_tmp;
	logic [MAG_W-1:0]      hi_al, lo_al, ma_al, mb_al;
	logic [7:0]            ex_al;

	// combine
	logic                  sb_eff;
	logic [MAG_W-1:0]      comb_mag;
	logic                  comb_sgn;

	// multiply, divide, convert
	logic [2*SIG_W-1:0]    prod;
	logic                  div_ge;
	logic                  itof_neg;
	logic [31:0]           itof_v;
	logic [SIG_W:0]        dv_t, dv_diff;
	logic                  dv_q;

	// normalize and round
	logic                  upper_nz;
	logic [SIG_W:0]        rsum;
	logic                  ex_oor;

	assign in_a = data_in[31:0];
	assign in_b = data_in[63:32];

	assign is_div  = (op_q == OP_DIV);
	assign special = (is_div && (fb_q == '0)) ||
		!(op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL || op_q == OP_DIV ||
		  op_q == OP_ITOF || op_q == OP_UTOF);

	// operand alignment: exact up to the limit, rounded beyond
	always_comb begin
		swap    = (eb_q > ea_q);
		hi_e    = swap ? eb_q : ea_q;
		lo_e    = swap ? ea_q : eb_q;
		hi_m    = swap ? fb_q : fa_q;
		lo_m    = swap ? fa_q : fb_q;
		exp_gap = hi_e - lo_e;
		rsh     = exp_gap - ALIGN_LIMIT;
		lo_tmp  = lo_m >> (rsh - 8'd1);
		hi_al   = {{(MAG_W-SIG_W){1'b0}}, hi_m};
		lo_al   = {{(MAG_W-SIG_W){1'b0}}, lo_m};
		ex_al   = hi_e;
		if (exp_gap == 8'd0) begin
			ex_al = hi_e;
		end else if (exp_gap <= ALIGN_LIMIT) begin
			hi_al = hi_al << exp_gap;
			ex_al = lo_e;
		end else begin
			hi_al = hi_al << ALIGN_LIMIT;
			ex_al = hi_e - ALIGN_LIMIT;
			lo_al = {{(MAG_W-SIG_W){1'b0}}, (lo_m >> rsh)} +
				{{(MAG_W-1){1'b0}}, lo_tmp[0]};
		end
		ma_al = swap ? lo_al : hi_al;
		mb_al = swap ? hi_al : lo_al;
	end

	// signed magnitude add
	always_comb begin
		sb_eff = sb_q ^ (op_q == OP_SUB);
		if (sa_q == sb_eff) begin
			comb_mag = mag_q + aux_q;
			comb_sgn = sa_q;
		end else if (aux_q > mag_q) begin
			comb_mag = aux_q - mag_q;
			comb_sgn = sb_eff;
		end else begin
			comb_mag = mag_q - aux_q;
			comb_sgn = sa_q;
		end
	end

	// multiplier, divider step and integer magnitude
	always_comb begin
		prod     = fa_q * fb_q;
		div_ge   = (fa_q >= fb_q);
		itof_neg = (op_q == OP_ITOF) && raw_a_q[31];
		itof_v   = itof_neg ? (32'd0 - raw_a_q) : raw_a_q;
		dv_t     = {rem_q, nbit_q};
		dv_diff  = dv_t - {1'b0, fb_q};
		dv_q     = (dv_t >= {1'b0, fb_q});
	end

	// normalization and packing helpers
	always_comb begin
		upper_nz = |mag_q[MAG_W-1:SIG_W];
		rsum     = mag_q[SIG_W:0] + {{SIG_W{1'b0}}, rbit_q};
		ex_oor   = ex_q[EXP_W-1] || (|ex_q[EXP_W-2:8]);
	end

	always_comb begin
		sts.special   = special;
		sts.is_addsub = (op_q == OP_ADD) || (op_q == OP_SUB);
		sts.is_div    = is_div;
		sts.div_last  = (cnt_q == 5'd0);
		sts.norm_done = (mag_q == '0) || (!upper_nz && mag_q[SIG_W-1]);
		sts.out_free  = !ovalid_q || m_tready;
	end

	// operand and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_in;
			sa_q    <= in_a[31];
			sb_q    <= in_b[31];
			ea_q    <= in_a[30:23];
			eb_q    <= in_b[30:23];
			fa_q    <= {|in_a[30:0], in_a[22:0]};
			fb_q    <= {|in_b[30:0], in_b[22:0]};
			raw_a_q <= in_a;
		end
		if (cmd.exec) begin
			rbit_q     <= 1'b0;
			spec_sel_q <= special;
			spec_q     <= is_div ? {sa_q ^ sb_q, EXP_TOP, 23'd0} : 32'd0;
			case (op_q)
				OP_ADD, OP_SUB: begin
					mag_q <= ma_al;
					aux_q <= mb_al;
					ex_q  <= $signed({3'd0, ex_al});
				end
				OP_MUL: begin
					mag_q <= {{(MAG_W-(2*SIG_W-23)){1'b0}}, prod[2*SIG_W-1:23]};
					ex_q  <= $signed({3'd0, ea_q}) + $signed({3'd0, eb_q}) -
						$signed({3'd0, BIAS});
					sgn_q <= sa_q ^ sb_q;
				end
				OP_DIV: begin
					mag_q  <= '0;
					sgn_q  <= sa_q ^ sb_q;
					cnt_q  <= 5'(QUO_W - 1);
					rem_q  <= div_ge ? {1'b0, fa_q[SIG_W-1:1]} : fa_q;
					nbit_q <= div_ge ? fa_q[0] : 1'b0;
					ex_q   <= $signed({3'd0, ea_q}) - $signed({3'd0, eb_q}) +
						(div_ge ? 11'sd126 : 11'sd125);
				end
				default: begin
					mag_q <= {1'b0, itof_v, 23'd0};
					ex_q  <= $signed({3'd0, BIAS});
					sgn_q <= itof_neg;
				end
			endcase
		end
		if (cmd.combine) begin
			mag_q <= comb_mag;
			sgn_q <= comb_sgn;
		end
		if (cmd.div_step) begin
			mag_q  <= {mag_q[MAG_W-2:0], dv_q};
			rem_q  <= dv_q ? dv_diff[SIG_W-1:0] : dv_t[SIG_W-1:0];
			nbit_q <= 1'b0;
			cnt_q  <= cnt_q - 5'd1;
		end
		if (cmd.norm_step) begin
			if (upper_nz) begin
				mag_q  <= mag_q >> 1;
				rbit_q <= mag_q[0];
				ex_q   <= ex_q + 11'sd1;
			end else begin
				mag_q <= mag_q << 1;
				ex_q  <= ex_q - 11'sd1;
			end
		end
		if (cmd.round) begin
			if (mag_q == '0) begin
				sgn_q <= 1'b0;
				ex_q  <= '0;
			end else if (rsum[SIG_W]) begin
				mag_q <= {{(MAG_W-SIG_W){1'b0}}, rsum[SIG_W:1]};
				ex_q  <= ex_q + 11'sd1;
			end else begin
				mag_q <= {{(MAG_W-SIG_W-1){1'b0}}, rsum};
			end
		end
	end

	// output register, freed by the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.emit) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			obits_q <= spec_sel_q ? spec_q : {sgn_q, ex_q[7:0], mag_q[22:0]};
			oflag_q <= spec_sel_q ? 1'b0 : ex_oor;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = obits_q;
	assign m_tuser  = oflag_q;

endmodule

/* sv/f32asmd_ctrl.sv */
// sequencing controller of the single-precision arithmetic unit
module f32asmd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  f32asmd_pkg::sts_t  sts,
	output f32asmd_pkg::cmd_t  cmd
);
	import f32asmd_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_COMB  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_NORM  = 3'd4;
	localparam logic [2:0] ST_ROUND = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0] state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = s_tvalid;
				if (s_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.special)        state_d = ST_FIN;
				else if (sts.is_addsub) state_d = ST_COMB;
				else if (sts.is_div)    state_d = ST_DIV;
				else                    state_d = ST_NORM;
			end
			ST_COMB: begin
				cmd.combine = 1'b1;
				state_d     = ST_NORM;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_NORM;
			end
			ST_NORM: begin
				if (sts.norm_done) state_d = ST_ROUND;
				else cmd.norm_step = 1'b1;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

/* sv/float32_add_sub_mul_div_unit_core.sv */
// top level of the single-precision add, subtract, multiply, divide unit
// usage:
//   input channel s_*: one transfer per operation; s_tuser carries the
//   operation code, s_tdata carries operand a (low word) and operand b.
//   output channel m_*: one transfer per operation; m_tdata is the packed
//   float, m_tuser flags an exponent that left 0..255 and was wrapped.
// timing:
//   one item at a time; s_tready is high only while the controller is idle.
//   sequence from the accepting edge to m_tvalid: add/sub run exec,
//   combine, one step per normalization shift, round and output;
//   multiply and conversions skip combine (up to 31 shifts for a wide
//   integer); divide runs 25 restoring quotient steps, then one
//   normalization shift and round; fixed results such as divide by zero go
//   from exec to output. s_tready rises as the result is written.
//   The result sits in an output register; a new item is taken while it
//   waits, and the unit holds its next result until the receiver frees it.
// reset:
//   arst_n clears the controller and the output valid; nothing else.
module float32_add_sub_mul_div_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
	input  logic [2:0]  s_tuser,   // operation [2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result_bits [31:0]
	output logic [0:0]  m_tuser    // exponent_out_of_range [0]
);
	import f32asmd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	f32asmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	f32asmd_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.op_in    (s_tuser),
		.data_in  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
